// File: rtl/ipv4_receive_header_check_defines.svh
// Assertion helpers for the RTL, used by irhc_queue. Both expect clk and arst_n in scope.
`ifndef IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECK_DEFINES_SVH

// same-cycle implication
`define IRHC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IRHC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/irhc_pkg.sv
`default_nettype none
package irhc_pkg;

	typedef enum logic [2:0] {
		ST_ACCEPT   = 3'd0,
		ST_VERSION  = 3'd1,
		ST_HDR_LEN  = 3'd2,
		ST_TTL      = 3'd3,
		ST_CHECKSUM = 3'd4,
		ST_DEST     = 3'd5
	} status_t;

	typedef struct packed {
		logic        is_verdict;
		status_t     status;
		logic [7:0]  payload_byte;
		logic        end_of_output;
	} result_t;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [3:0]  IP_VERSION     = 4'd4;
	localparam logic [5:0]  MIN_HDR_BYTES  = 6'd20;
	localparam logic [5:0]  TTL_OFFSET     = 6'd8;
	localparam logic [5:0]  DEST_FIRST     = 6'd16;
	localparam logic [5:0]  DEST_LAST      = 6'd19;
	localparam logic [15:0] CKSUM_GOOD     = 16'hffff;
	localparam logic [31:0] BCAST_ADDR     = 32'hffff_ffff;

endpackage
`default_nettype wire

// File: rtl/irhc_front.sv
`default_nettype none
module irhc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic [7:0]        packet_byte,
	input  wire logic              end_of_packet,
	input  wire logic [31:0]       local_address,
	output logic                   push,
	output irhc_pkg::result_t      push_data
);
	import irhc_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_FORWARD,
		PH_DROP
	} phase_t;

	phase_t      phase_q;
	logic [5:0]  byte_index_q;
	logic [5:0]  header_bytes_q;
	logic [15:0] sum_q;
	logic [7:0]  hold_q;
	logic [31:0] dest_q;
	status_t     early_q;

	logic        accept;
	logic        first;
	logic [5:0]  hb_first;
	logic [5:0]  hb;
	status_t     early_first;
	status_t     early_cur;
	status_t     early_next;
	logic        short_hdr;
	logic [16:0] sum_wide;
	logic [15:0] sum_fold;
	logic [15:0] sum_next;
	logic [31:0] dest_next;
	logic        last_hdr;
	status_t     verdict;
	logic        verdict_last;

	assign accept   = in_valid && in_ready;
	assign first    = (byte_index_q == '0);
	assign hb_first = {packet_byte[3:0], 2'b00};
	assign hb       = first ? hb_first : header_bytes_q;

	always_comb begin
		if (packet_byte[7:4] != IP_VERSION) begin
			early_first = ST_VERSION;
		end else if (hb_first < MIN_HDR_BYTES) begin
			early_first = ST_HDR_LEN;
		end else begin
			early_first = ST_ACCEPT;
		end
	end

	assign early_cur = first ? early_first : early_q;
	assign short_hdr = first && (hb_first < MIN_HDR_BYTES);

	// end-around carry add of the big-endian word
	assign sum_wide = {1'b0, sum_q} + {1'b0, hold_q, packet_byte};
	assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
	assign sum_next = byte_index_q[0] ? sum_fold : sum_q;

	assign early_next = (byte_index_q == TTL_OFFSET && packet_byte == 8'd0
		&& early_cur == ST_ACCEPT) ? ST_TTL : early_cur;

	assign dest_next = (byte_index_q >= DEST_FIRST && byte_index_q <= DEST_LAST)
		? {dest_q[23:0], packet_byte} : dest_q;

	assign last_hdr = ({1'b0, byte_index_q} + 7'd1) == {1'b0, hb};

	always_comb begin
		if (early_next != ST_ACCEPT) begin
			verdict = early_next;
		end else if (sum_next != CKSUM_GOOD) begin
			verdict = ST_CHECKSUM;
		end else if (dest_next != local_address && dest_next != BCAST_ADDR) begin
			verdict = ST_DEST;
		end else begin
			verdict = ST_ACCEPT;
		end
	end

	assign verdict_last = (verdict != ST_ACCEPT) || end_of_packet;

	always_comb begin
		push      = 1'b0;
		push_data = '{is_verdict: 1'b0, status: ST_ACCEPT, payload_byte: 8'd0,
			end_of_output: 1'b0};
		if (accept) begin
			case (phase_q)
				PH_FORWARD: begin
					push      = 1'b1;
					push_data = '{is_verdict: 1'b0, status: ST_ACCEPT,
						payload_byte: packet_byte, end_of_output: end_of_packet};
				end
				PH_HEADER: begin
					if (short_hdr) begin
						push      = 1'b1;
						push_data = '{is_verdict: 1'b1, status: early_first,
							payload_byte: 8'd0, end_of_output: 1'b1};
					end else if (last_hdr) begin
						push      = 1'b1;
						push_data = '{is_verdict: 1'b1, status: verdict,
							payload_byte: 8'd0, end_of_output: verdict_last};
					end else if (end_of_packet) begin
						push      = 1'b1;
						push_data = '{is_verdict: 1'b1,
							status: (early_next == ST_VERSION) ? ST_VERSION : ST_HDR_LEN,
							payload_byte: 8'd0, end_of_output: 1'b1};
					end
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			byte_index_q   <= '0;
			header_bytes_q <= '0;
			sum_q          <= '0;
			hold_q         <= '0;
			dest_q         <= '0;
			early_q        <= ST_ACCEPT;
		end else if (accept) begin
			if (end_of_packet) begin
				phase_q        <= PH_HEADER;
				byte_index_q   <= '0;
				header_bytes_q <= '0;
				sum_q          <= '0;
				hold_q         <= '0;
				dest_q         <= '0;
				early_q        <= ST_ACCEPT;
			end else if (phase_q == PH_HEADER) begin
				header_bytes_q <= hb;
				if (short_hdr) begin
					early_q <= early_first;
					phase_q <= PH_DROP;
				end else begin
					early_q <= early_next;
					sum_q   <= sum_next;
					dest_q  <= dest_next;
					if (!byte_index_q[0]) begin
						hold_q <= packet_byte;
					end
					if (last_hdr) begin
						phase_q <= (verdict != ST_ACCEPT) ? PH_DROP : PH_FORWARD;
					end else begin
						byte_index_q <= byte_index_q + 6'd1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/irhc_queue.sv
`default_nettype none
`include "ipv4_receive_header_check_defines.svh"
module irhc_queue #(
	parameter int unsigned DEPTH = irhc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire irhc_pkg::result_t wr_data,
	input  wire logic              rd_en,
	output irhc_pkg::result_t      rd_data,
	output logic                   not_empty,
	output logic                   full
);
	import irhc_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	result_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_FULL);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`IRHC_ASSERT_IMP(a_no_overflow, wr_en, !full, "queue written while full")
	`IRHC_ASSERT_IMP(a_no_underflow, rd_en, not_empty, "queue read while empty")
	`IRHC_ASSERT_NXT(a_count_up, wr_en && !rd_en, count_q == $past(count_q) + CNT_W'(1), "queue count did not rise")
	`IRHC_ASSERT_NXT(a_count_down, rd_en && !wr_en, count_q == $past(count_q) - CNT_W'(1), "queue count did not fall")

endmodule
`default_nettype wire

// File: rtl/irhc_back.sv
`default_nettype none
module irhc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire irhc_pkg::result_t head,
	input  wire logic              head_valid,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);
	import irhc_pkg::*;

	result_t out_q;
	logic    valid_q;

	// refill the output register when it is empty or being taken
	assign pop = head_valid && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_tready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {5'd0, out_q.payload_byte, out_q.status};
	assign m_tuser  = out_q.is_verdict;
	assign m_tlast  = out_q.end_of_output;

endmodule
`default_nettype wire

// File: rtl/ipv4_receive_header_check.sv
// IPv4 receive header check.
// Slave stream: one packet byte per transfer in s_tdata[7:0], s_tlast on the
// packet's final byte. Master stream: one result per transfer. m_tuser is 1
// for a header verdict, 0 for a forwarded payload byte; m_tdata carries
// status (verdict code, 0 = accept) and the payload byte; m_tlast marks the
// last result of a packet. Rejected packets are dropped after their verdict.
// local_address is written with local_address_wr_en; the user must write it only
// while the block is idle: the block itself does not enforce this.
// Throughput: one byte per cycle while the queue is not full. Each byte is
// classified combinationally by the front end (16-bit end-around add, compares);
// a result, if any, goes to the queue, then to the output register (m_tvalid).
// Stall: the queue (QUEUE_DEPTH entries) plus the output register absorb a
// stalled receiver; s_tready drops only when the queue is full, and bytes
// that produce no result still need a free queue slot to be taken.
// Reset: arst_n clears the queue, the output register and the header state;
// local_address returns to zero.
`default_nettype none
module ipv4_receive_header_check #(
	parameter int unsigned QUEUE_DEPTH = irhc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        local_address_wr_en,
	input  wire logic [31:0] local_address,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] packet_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [2:0] status, [10:3] payload_byte, rest zero
	output logic             m_tuser,   // is_verdict
	output logic             m_tlast
);
	import irhc_pkg::*;

	logic [31:0] local_address_q;
	logic        push;
	result_t     push_data;
	result_t     head;
	logic        head_valid;
	logic        pop;
	logic        full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
		end else if (local_address_wr_en) begin
			local_address_q <= local_address;
		end
	end

	assign s_tready = !full;

	irhc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.packet_byte   (s_tdata),
		.end_of_packet (s_tlast),
		.local_address (local_address_q),
		.push          (push),
		.push_data     (push_data)
	);

	irhc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push),
		.wr_data   (push_data),
		.rd_en     (pop),
		.rd_data   (head),
		.not_empty (head_valid),
		.full      (full)
	);

	irhc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire
